@@ design/heavy_edge_matcher_assert.svh @@
// Assertion macros used by the checker of the heavy edge matcher.
// No dependencies; expects i_clk and i_rst_n in the scope of each use.
`ifndef HEAVY_EDGE_MATCHER_ASSERT_SVH
`define HEAVY_EDGE_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HEM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HEM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hem_pkg.sv @@
// Shared types and constants of the heavy edge matcher.
// No dependencies; used by the top level, its checker and the testbench.
package hem_pkg;

    localparam int MAX_LOCAL_DEF    = 4096;
    localparam int MAX_VERTICES_DEF = 65536;

    // Taken-bitmap storage: bits per memory row.
    localparam int BMP_ROW_W = 32;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int ROW_W    = 12;
    localparam int ID_W     = 16;
    localparam int WEIGHT_W = 32;
    localparam int END_W    = 17;
    localparam int ENTRY_W  = ID_W + 1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_PRESET = 2'd1,
        OP_EDGE   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SELF     = 2'd1,
        ST_PRECEDES = 2'd2
    } t_status;

    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic REG_RANGE_START = 1'b0;
    localparam logic REG_RANGE_END   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_READ,
        S_COMMIT,
        S_LINK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } t_entry;

endpackage

@@ design/hem_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hem_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/heavy_edge_matcher.sv @@
// Heavy edge matcher top level: partner table, taken bitmap and row sequencer.
// Depends on hem_pkg and hem_ram.
//
//  channel   direction  handshake                  payload
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//  item      in         i_in_valid / o_in_ready    i_operation .. i_preset_matched
//  result    out        o_out_valid / i_out_ready  o_kind .. o_status
//
// A preset is taken in idle, an edge is evaluated, the last edge of a row
// then commits, links and emits, a read reads and emits, and a clear passes
// over all MAX_LOCAL or MAX_VERTICES/32 rows (larger). The single write port
// of each memory sets the order: a commit writes the row entry and then the
// partner entry or the bitmap row. After reset the same clearing pass runs
// before the first item is taken; config writes are taken throughout.
// A waiting result sits in the output register; a stall only holds the
// next result-producing item in its emit step.
module heavy_edge_matcher #(
    parameter int MAX_LOCAL    = hem_pkg::MAX_LOCAL_DEF,
    parameter int MAX_VERTICES = hem_pkg::MAX_VERTICES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hem_pkg::APB_AW-1:0]         paddr,
    input  logic [hem_pkg::APB_DW-1:0]         pwdata,
    output logic [hem_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic [hem_pkg::ROW_W-1:0]          i_row,
    input  logic [hem_pkg::ID_W-1:0]           i_neighbor,
    input  logic signed [hem_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                               i_last_in_row,
    input  logic [hem_pkg::ID_W-1:0]           i_preset_partner,
    input  logic                               i_preset_matched,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_kind,
    output logic [hem_pkg::ROW_W-1:0]          o_vertex,
    output logic [hem_pkg::ID_W-1:0]           o_partner,
    output logic                               o_has_partner,
    output logic [1:0]                         o_status
);

    localparam int LW        = $clog2(MAX_LOCAL);
    localparam int BMP_W     = (MAX_VERTICES < hem_pkg::BMP_ROW_W) ? MAX_VERTICES
                                                                  : hem_pkg::BMP_ROW_W;
    localparam int BSH       = $clog2(BMP_W);
    localparam int BMP_DEPTH = (MAX_VERTICES + BMP_W - 1) / BMP_W;
    localparam int BAW       = (BMP_DEPTH > 1) ? $clog2(BMP_DEPTH) : 1;
    localparam int CLR_N     = (MAX_LOCAL > BMP_DEPTH) ? MAX_LOCAL : BMP_DEPTH;
    localparam int CNW       = $clog2(CLR_N);
    localparam int END_W     = hem_pkg::END_W;
    localparam int ID_W      = hem_pkg::ID_W;
    localparam int ROW_W     = hem_pkg::ROW_W;
    localparam int WEIGHT_W  = hem_pkg::WEIGHT_W;

    // Configuration registers
    logic [ID_W-1:0]  r_range_start;
    logic [END_W-1:0] r_range_end;
    logic             apb_wr;

    // Sequencer
    hem_pkg::t_state r_state, n_state;
    logic [CNW-1:0]  r_clr_cnt, n_clr_cnt;

    // Captured item
    logic [ROW_W-1:0]           r_row, n_row;
    logic [ID_W-1:0]            r_nb, n_nb;
    logic signed [WEIGHT_W-1:0] r_weight, n_weight;
    logic                       r_last, n_last;

    // Accumulator
    logic [ID_W-1:0]            r_best_partner, n_best_partner;
    logic signed [WEIGHT_W-1:0] r_best_weight, n_best_weight;
    logic                       r_best_valid, n_best_valid;
    logic [1:0]                 r_row_error, n_row_error;   // bit 0 self, bit 1 precedes

    logic             r_commit, n_commit;
    hem_pkg::t_entry  r_entry, n_entry;

    // Pending result
    logic             r_res_kind, n_res_kind;
    hem_pkg::t_entry  r_res_entry, n_res_entry;
    hem_pkg::t_status r_res_status, n_res_status;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic              r_out_kind, n_out_kind;
    logic [ROW_W-1:0]  r_out_vertex, n_out_vertex;
    logic [ID_W-1:0]   r_out_partner, n_out_partner;
    logic              r_out_has, n_out_has;
    hem_pkg::t_status  r_out_status, n_out_status;

    // Memory ports
    logic             pt_we;
    logic [LW-1:0]    pt_waddr;
    hem_pkg::t_entry  pt_wdata;
    hem_pkg::t_entry  pa_rd, pb_rd;
    logic             bm_we, bm_re;
    logic [BAW-1:0]   bm_waddr, bm_raddr;
    logic [BMP_W-1:0] bm_wdata, bm_rd;

    logic in_accept;

    // Range decode
    logic [END_W-1:0] range_span, owned_n, local_end, gid;
    logic             range_empty, range_capped;

    // Edge evaluation
    logic row_owned, row_free, above_start, is_self, is_local, in_bmp;
    logic taken, consider, better;
    logic best_local, best_in_bmp, precedes;
    logic [1:0] link_error;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[hem_pkg::APB_AW-1] == hem_pkg::REG_RANGE_END)
                    ? hem_pkg::APB_DW'(r_range_end) : hem_pkg::APB_DW'(r_range_start);

    assign o_in_ready = (r_state == hem_pkg::S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign bm_re      = in_accept || (r_state == hem_pkg::S_COMMIT);
    assign bm_raddr   = (r_state == hem_pkg::S_COMMIT) ? BAW'(r_best_partner >> BSH)
                                                       : BAW'(i_neighbor >> BSH);

    assign range_span   = r_range_end - END_W'(r_range_start);
    assign range_empty  = r_range_end <= END_W'(r_range_start);
    assign range_capped = range_span > END_W'(MAX_LOCAL);
    assign owned_n      = range_empty ? '0 : (range_capped ? END_W'(MAX_LOCAL) : range_span);
    assign local_end    = range_empty ? END_W'(r_range_start)
                        : (range_capped ? END_W'(r_range_start) + END_W'(MAX_LOCAL)
                                        : r_range_end);
    assign gid          = END_W'(r_range_start) + END_W'(r_row);

    assign row_owned   = END_W'(r_row) < owned_n;
    assign row_free    = !pa_rd.valid;
    assign above_start = r_nb >= r_range_start;
    assign is_self     = END_W'(r_nb) == gid;
    assign is_local    = END_W'(r_nb) < local_end;
    assign in_bmp      = 32'(r_nb) < 32'(MAX_VERTICES);
    assign taken       = is_local ? pb_rd.valid : (in_bmp ? bm_rd[r_nb[BSH-1:0]] : 1'b1);
    assign consider    = row_free && above_start;
    assign better      = consider && !is_self && !taken && (r_weight > r_best_weight);

    assign best_local  = END_W'(r_best_partner) < local_end;
    assign best_in_bmp = 32'(r_best_partner) < 32'(MAX_VERTICES);
    assign precedes    = r_commit && best_local && !(gid < END_W'(r_best_partner));
    assign link_error  = {r_row_error[1] | precedes, r_row_error[0]};

    always_comb begin
        n_state        = r_state;
        n_clr_cnt      = r_clr_cnt;
        n_row          = r_row;
        n_nb           = r_nb;
        n_weight       = r_weight;
        n_last         = r_last;
        n_best_partner = r_best_partner;
        n_best_weight  = r_best_weight;
        n_best_valid   = r_best_valid;
        n_row_error    = r_row_error;
        n_commit       = r_commit;
        n_entry        = r_entry;
        n_res_kind     = r_res_kind;
        n_res_entry    = r_res_entry;
        n_res_status   = r_res_status;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_kind     = r_out_kind;
        n_out_vertex   = r_out_vertex;
        n_out_partner  = r_out_partner;
        n_out_has      = r_out_has;
        n_out_status   = r_out_status;
        pt_we          = 1'b0;
        pt_waddr       = LW'(r_row);
        pt_wdata       = '0;
        bm_we          = 1'b0;
        bm_waddr       = BAW'(r_best_partner >> BSH);
        bm_wdata       = bm_rd | (BMP_W'(1) << r_best_partner[BSH-1:0]);

        case (r_state)
            hem_pkg::S_CLEAR: begin
                pt_we    = 32'(r_clr_cnt) < 32'(MAX_LOCAL);
                pt_waddr = LW'(r_clr_cnt);
                pt_wdata = '0;
                bm_we    = 32'(r_clr_cnt) < 32'(BMP_DEPTH);
                bm_waddr = BAW'(r_clr_cnt);
                bm_wdata = '0;
                if (r_clr_cnt == CNW'(CLR_N - 1)) begin
                    n_clr_cnt = '0;
                    n_state   = hem_pkg::S_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            hem_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_row    = i_row;
                    n_nb     = i_neighbor;
                    n_weight = i_weight;
                    n_last   = i_last_in_row;
                    case (hem_pkg::t_op'(i_operation))
                        hem_pkg::OP_CLEAR: begin
                            n_best_partner = '0;
                            n_best_weight  = '1;
                            n_best_valid   = 1'b0;
                            n_row_error    = '0;
                            n_clr_cnt      = '0;
                            n_state        = hem_pkg::S_CLEAR;
                        end
                        hem_pkg::OP_PRESET: begin
                            pt_we          = 32'(i_row) < 32'(MAX_LOCAL);
                            pt_waddr       = LW'(i_row);
                            pt_wdata.valid = i_preset_matched;
                            pt_wdata.id    = i_preset_partner;
                        end
                        hem_pkg::OP_EDGE: begin
                            n_state = hem_pkg::S_EVAL;
                        end
                        hem_pkg::OP_READ: begin
                            n_state = hem_pkg::S_READ;
                        end
                        default: begin
                            n_state = hem_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            hem_pkg::S_READ: begin
                n_res_kind   = hem_pkg::KIND_READ;
                n_res_entry  = (32'(r_row) < 32'(MAX_LOCAL)) ? pa_rd : '0;
                n_res_status = hem_pkg::ST_OK;
                n_state      = hem_pkg::S_EMIT;
            end
            hem_pkg::S_EVAL: begin
                if (!row_owned) begin
                    // Unowned row: drop the edge, reset the accumulator on its last one
                    if (r_last) begin
                        n_best_partner = '0;
                        n_best_weight  = '1;
                        n_best_valid   = 1'b0;
                        n_row_error    = '0;
                    end
                    n_state = hem_pkg::S_IDLE;
                end else begin
                    if (consider && is_self) begin
                        n_row_error[0] = 1'b1;
                    end
                    if (better) begin
                        n_best_partner = r_nb;
                        n_best_weight  = r_weight;
                        n_best_valid   = 1'b1;
                    end
                    if (r_last) begin
                        n_entry  = pa_rd;
                        n_commit = row_free && (better || r_best_valid);
                        n_state  = hem_pkg::S_COMMIT;
                    end else begin
                        n_state = hem_pkg::S_IDLE;
                    end
                end
            end
            hem_pkg::S_COMMIT: begin
                // Write the row's own entry; the bitmap row is fetched meanwhile
                pt_we          = r_commit;
                pt_waddr       = LW'(r_row);
                pt_wdata.valid = 1'b1;
                pt_wdata.id    = r_best_partner;
                n_state        = hem_pkg::S_LINK;
            end
            hem_pkg::S_LINK: begin
                if (r_commit && best_local) begin
                    pt_we          = 1'b1;
                    pt_waddr       = LW'(r_best_partner - r_range_start);
                    pt_wdata.valid = 1'b1;
                    pt_wdata.id    = gid[ID_W-1:0];
                end else if (r_commit && best_in_bmp) begin
                    bm_we = 1'b1;
                end
                n_res_kind = hem_pkg::KIND_ROW;
                if (r_commit) begin
                    n_res_entry.valid = 1'b1;
                    n_res_entry.id    = r_best_partner;
                end else begin
                    n_res_entry = r_entry;
                end
                if (link_error[0]) begin
                    n_res_status = hem_pkg::ST_SELF;
                end else if (link_error[1]) begin
                    n_res_status = hem_pkg::ST_PRECEDES;
                end else begin
                    n_res_status = hem_pkg::ST_OK;
                end
                n_best_partner = '0;
                n_best_weight  = '1;
                n_best_valid   = 1'b0;
                n_row_error    = '0;
                n_state        = hem_pkg::S_EMIT;
            end
            hem_pkg::S_EMIT: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = r_res_kind;
                    n_out_vertex  = r_row;
                    n_out_partner = r_res_entry.valid ? r_res_entry.id : '0;
                    n_out_has     = r_res_entry.valid;
                    n_out_status  = r_res_status;
                    n_state       = hem_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hem_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= hem_pkg::S_CLEAR;
            r_clr_cnt      <= '0;
            r_range_start  <= '0;
            r_range_end    <= '0;
            r_out_valid    <= 1'b0;
            r_best_partner <= '0;
            r_best_weight  <= '1;
            r_best_valid   <= 1'b0;
            r_row_error    <= '0;
        end else begin
            r_state        <= n_state;
            r_clr_cnt      <= n_clr_cnt;
            r_out_valid    <= n_out_valid;
            r_best_partner <= n_best_partner;
            r_best_weight  <= n_best_weight;
            r_best_valid   <= n_best_valid;
            r_row_error    <= n_row_error;
            if (apb_wr) begin
                case (paddr[hem_pkg::APB_AW-1])
                    hem_pkg::REG_RANGE_START: begin
                        r_range_start <= pwdata[ID_W-1:0];
                    end
                    hem_pkg::REG_RANGE_END: begin
                        r_range_end <= pwdata[END_W-1:0];
                    end
                    default: begin
                        r_range_start <= r_range_start;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row         <= n_row;
        r_nb          <= n_nb;
        r_weight      <= n_weight;
        r_last        <= n_last;
        r_commit      <= n_commit;
        r_entry       <= n_entry;
        r_res_kind    <= n_res_kind;
        r_res_entry   <= n_res_entry;
        r_res_status  <= n_res_status;
        r_out_kind    <= n_out_kind;
        r_out_vertex  <= n_out_vertex;
        r_out_partner <= n_out_partner;
        r_out_has     <= n_out_has;
        r_out_status  <= n_out_status;
    end

    // Two copies of the partner table, written together: one looks up the
    // row, the other the neighbor, in the same cycle.
    hem_ram #(
        .WIDTH (hem_pkg::ENTRY_W),
        .DEPTH (MAX_LOCAL)
    ) u_ptab_row (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (in_accept),
        .i_raddr (LW'(i_row)),
        .o_rdata (pa_rd)
    );

    hem_ram #(
        .WIDTH (hem_pkg::ENTRY_W),
        .DEPTH (MAX_LOCAL)
    ) u_ptab_nb (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (in_accept),
        .i_raddr (LW'(i_neighbor - r_range_start)),
        .o_rdata (pb_rd)
    );

    hem_ram #(
        .WIDTH (BMP_W),
        .DEPTH (BMP_DEPTH)
    ) u_taken_bmp (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rd)
    );

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_vertex      = r_out_vertex;
    assign o_partner     = r_out_partner;
    assign o_has_partner = r_out_has;
    assign o_status      = r_out_status;

endmodule

@@ design/hem_checker.sv @@
// Port-level checker for the heavy edge matcher, bound to the top level.
// Depends on hem_pkg and heavy_edge_matcher_assert.svh.
`include "heavy_edge_matcher_assert.svh"

module hem_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [1:0]                i_operation,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic                      o_kind,
    input logic [hem_pkg::ROW_W-1:0] o_vertex,
    input logic [hem_pkg::ID_W-1:0]  o_partner,
    input logic                      o_has_partner,
    input logic [1:0]                o_status
);

    // A stalled result keeps its payload.
    `HEM_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_vertex) && $stable(o_partner) && $stable(o_status), "result changed while stalled")

    // An unmatched vertex reports partner zero.
    `HEM_ASSERT_IMP(a_no_partner_zero, o_out_valid && !o_has_partner, o_partner == '0, "partner set without match")

    // Read data never carries a row status.
    `HEM_ASSERT_IMP(a_read_ok, o_out_valid && o_kind == hem_pkg::KIND_READ, o_status == hem_pkg::ST_OK, "read result with status")

    // A preset produces no result.
    `HEM_ASSERT_NXT(a_preset_silent, i_in_valid && o_in_ready && i_operation == hem_pkg::OP_PRESET, !$rose(o_out_valid), "result after preset")

    // An edge occupies the sequencer for its evaluation cycle.
    `HEM_ASSERT_NXT(a_edge_busy, i_in_valid && o_in_ready && i_operation == hem_pkg::OP_EDGE, !o_in_ready, "ready during edge evaluation")

endmodule

bind heavy_edge_matcher hem_checker u_hem_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_vertex      (o_vertex),
    .o_partner     (o_partner),
    .o_has_partner (o_has_partner),
    .o_status      (o_status)
);

@@ verif/heavy_edge_matcher_test.sv @@
// Self-checking testbench of heavy_edge_matcher: directed rows, range extremes, random
// row traffic with idle gaps and output stalls, checked against an in-bench predictor.
// Depends on hem_pkg and heavy_edge_matcher.
`timescale 1ns / 100ps

module heavy_edge_matcher_test;
    import hem_pkg::*;

    localparam int TB_MAX_LOCAL    = MAX_LOCAL_DEF;
    localparam int TB_MAX_VERTICES = MAX_VERTICES_DEF;
    localparam int CLEAR_CYCLES    = ((TB_MAX_LOCAL > TB_MAX_VERTICES / BMP_ROW_W) ?
                                      TB_MAX_LOCAL : TB_MAX_VERTICES / BMP_ROW_W) + 1;
    localparam int CLEAR_SETTLE    = CLEAR_CYCLES + 16;
    localparam int ITEM_SETTLE     = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [APB_AW-1:0] ADDR_RANGE_START = APB_AW'(4 * int'(REG_RANGE_START));
    localparam logic [APB_AW-1:0] ADDR_RANGE_END   = APB_AW'(4 * int'(REG_RANGE_END));

    typedef struct {
        t_op                        op;
        logic [ROW_W-1:0]           row;
        logic [ID_W-1:0]            neighbor;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last;
        logic [ID_W-1:0]            preset_partner;
        logic                       preset_matched;
    } t_match_item;

    typedef struct {
        logic             kind;
        logic [ROW_W-1:0] vertex;
        logic [ID_W-1:0]  partner;
        logic             has_partner;
        t_status          status;
    } t_match_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [1:0]                 i_operation;
    logic [ROW_W-1:0]           i_row;
    logic [ID_W-1:0]            i_neighbor;
    logic signed [WEIGHT_W-1:0] i_weight;
    logic                       i_last_in_row;
    logic [ID_W-1:0]            i_preset_partner;
    logic                       i_preset_matched;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_kind;
    logic [ROW_W-1:0]           o_vertex;
    logic [ID_W-1:0]            o_partner;
    logic                       o_has_partner;
    logic [1:0]                 o_status;

    // predictor state
    logic [ID_W-1:0]  range_lo_q;
    logic [END_W-1:0] range_hi_q;
    t_entry           entry_table [TB_MAX_LOCAL];
    bit               remote_busy [TB_MAX_VERTICES];
    logic [ID_W-1:0]  acc_partner;
    longint           acc_weight;
    bit               acc_found;
    bit [1:0]         acc_flags;

    t_match_result expected_results[$];
    int            mismatch_count = 0;
    int            items_sent     = 0;
    int            settle_cycles  = ITEM_SETTLE;
    int            cycle_count    = 0;
    bit            idle_enable    = 1'b1;
    bit            hold_request   = 1'b0;

    heavy_edge_matcher i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_row            (i_row),
        .i_neighbor       (i_neighbor),
        .i_weight         (i_weight),
        .i_last_in_row    (i_last_in_row),
        .i_preset_partner (i_preset_partner),
        .i_preset_matched (i_preset_matched),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_vertex         (o_vertex),
        .o_partner        (o_partner),
        .o_has_partner    (o_has_partner),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void clear_accumulator();
        acc_partner = '0;
        acc_weight  = -1;
        acc_found   = 1'b0;
        acc_flags   = '0;
    endfunction

    function automatic void clear_match_tables();
        foreach (entry_table[i]) entry_table[i] = '0;
        foreach (remote_busy[i]) remote_busy[i] = 1'b0;
        clear_accumulator();
    endfunction

    function automatic bit [31:0] owned_rows();
        bit [31:0] span;
        if (range_hi_q <= range_lo_q)
            return 0;
        span = range_hi_q - range_lo_q;
        return (span > TB_MAX_LOCAL) ? TB_MAX_LOCAL : span;
    endfunction

    function automatic t_match_result entry_result(input logic kind,
                                                   input logic [ROW_W-1:0] row,
                                                   input t_entry entry,
                                                   input t_status status);
        t_match_result res;
        res.kind        = kind;
        res.vertex      = row;
        res.partner     = entry.valid ? entry.id : '0;
        res.has_partner = entry.valid;
        res.status      = status;
        return res;
    endfunction

    function automatic void predict_match(input t_match_item it, output bit emits,
                                          output t_match_result res);
        bit [31:0] n, local_end, gid, nb;
        longint    w;
        bit        row_free, taken;
        t_status   status;
        emits = 1'b0;
        res   = entry_result(KIND_ROW, '0, '0, ST_OK);
        case (it.op)
            OP_CLEAR: clear_match_tables();
            OP_PRESET: begin
                entry_table[it.row] = it.preset_matched ? {1'b1, it.preset_partner} : '0;
            end
            OP_READ: begin
                emits = 1'b1;
                res   = entry_result(KIND_READ, it.row, entry_table[it.row], ST_OK);
            end
            OP_EDGE: begin
                n = owned_rows();
                if (it.row >= n) begin
                    if (it.last)
                        clear_accumulator();
                    return;
                end
                local_end = range_lo_q + n;
                gid       = range_lo_q + it.row;
                nb        = it.neighbor;
                w         = it.weight;
                row_free  = !entry_table[it.row].valid;
                if (row_free && nb >= range_lo_q) begin
                    if (nb == gid) begin
                        acc_flags[0] = 1'b1;
                    end else begin
                        if (nb < local_end)
                            taken = entry_table[nb - range_lo_q].valid;
                        else if (nb < TB_MAX_VERTICES)
                            taken = remote_busy[nb];
                        else
                            taken = 1'b1;
                        // strict compare keeps the first of equal weights
                        if (!taken && w > acc_weight) begin
                            acc_partner = nb[ID_W-1:0];
                            acc_weight  = w;
                            acc_found   = 1'b1;
                        end
                    end
                end
                if (!it.last)
                    return;
                if (row_free && acc_found) begin
                    entry_table[it.row] = {1'b1, acc_partner};
                    if (acc_partner < local_end) begin
                        entry_table[acc_partner - range_lo_q] = {1'b1, gid[ID_W-1:0]};
                        if (!(gid < acc_partner))
                            acc_flags[1] = 1'b1;
                    end else if (acc_partner < TB_MAX_VERTICES) begin
                        remote_busy[acc_partner] = 1'b1;
                    end
                end
                if (acc_flags[0])
                    status = ST_SELF;
                else if (acc_flags[1])
                    status = ST_PRECEDES;
                else
                    status = ST_OK;
                emits = 1'b1;
                res   = entry_result(KIND_ROW, it.row, entry_table[it.row], status);
                clear_accumulator();
            end
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    // Fields an operation ignores still get random values.
    function automatic t_match_item blank_item(input t_op op);
        t_match_item it;
        it.op             = op;
        it.row            = $urandom;
        it.neighbor       = $urandom;
        it.weight         = $urandom;
        it.last           = $urandom_range(0, 1);
        it.preset_partner = $urandom;
        it.preset_matched = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic t_match_item make_edge(input logic [ROW_W-1:0] row,
                                              input logic [ID_W-1:0] nb,
                                              input logic signed [WEIGHT_W-1:0] w,
                                              input logic last);
        t_match_item it;
        it          = blank_item(OP_EDGE);
        it.row      = row;
        it.neighbor = nb;
        it.weight   = w;
        it.last     = last;
        return it;
    endfunction

    function automatic t_match_item make_preset(input logic [ROW_W-1:0] row,
                                                input logic [ID_W-1:0] partner,
                                                input logic matched);
        t_match_item it;
        it                = blank_item(OP_PRESET);
        it.row            = row;
        it.preset_partner = partner;
        it.preset_matched = matched;
        return it;
    endfunction

    function automatic t_match_item make_read(input logic [ROW_W-1:0] row);
        t_match_item it;
        it     = blank_item(OP_READ);
        it.row = row;
        return it;
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        bit [31:0] n;
        n = owned_rows();
        if (n > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(0, n - 1);
        return $urandom;
    endfunction

    // Bias neighbors toward the owned window and a small remote pool so that
    // taken vertices keep getting hit.
    function automatic logic [ID_W-1:0] pick_neighbor(input logic [ROW_W-1:0] row);
        bit [31:0]   n, local_end;
        int unsigned r;
        n         = owned_rows();
        local_end = range_lo_q + n;
        r         = $urandom_range(0, 99);
        if (r < 35 && n > 0)
            return range_lo_q + $urandom_range(0, n - 1);
        if (r < 45)
            return range_lo_q + row;
        if (r < 55 && range_lo_q > 0)
            return $urandom_range(0, range_lo_q - 1);
        if (r < 85 && local_end + 15 < TB_MAX_VERTICES)
            return local_end + $urandom_range(0, 15);
        return $urandom;
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return -1;
                default: return 0;
            endcase
        end
        if (r < 30)
            return $urandom | 32'h8000_0000;
        if (r < 80)
            return $urandom_range(0, 20);
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (!idle_enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- drivers ----------------

    task automatic send_item(input t_match_item it);
        int            gap;
        bit            emits;
        t_match_result res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= it.op;
        i_row            <= it.row;
        i_neighbor       <= it.neighbor;
        i_weight         <= it.weight;
        i_last_in_row    <= it.last;
        i_preset_partner <= it.preset_partner;
        i_preset_matched <= it.preset_matched;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_match(it, emits, res);
        if (emits)
            expected_results.push_back(res);
        items_sent++;
        settle_cycles = (it.op == OP_CLEAR) ? CLEAR_SETTLE : ITEM_SETTLE;
    endtask

    // Leaves psel high so that back-to-back writes never re-drive it in one step.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_range(input logic [ID_W-1:0] lo, input logic [END_W-1:0] hi);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (settle_cycles) @(posedge i_clk);
        write_reg(ADDR_RANGE_START, APB_DW'(lo));
        write_reg(ADDR_RANGE_END, APB_DW'(hi));
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        range_lo_q = lo;
        range_hi_q = hi;
    endtask

    task automatic send_row(input bit unterminated);
        logic [ROW_W-1:0] row;
        int               edges;
        row   = pick_row();
        edges = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        for (int e = 0; e < edges; e++) begin
            // hop rows mid-sequence: the accumulator carries over
            if (unterminated && $urandom_range(0, 2) == 0)
                row = pick_row();
            send_item(make_edge(row, pick_neighbor(row), pick_weight(),
                                !unterminated && e == edges - 1));
        end
    endtask

    task automatic run_random_mix(input int count);
        int               first;
        int unsigned      r;
        logic [ROW_W-1:0] row;
        logic [ID_W-1:0]  partner;
        first = items_sent;
        while (items_sent - first < count) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                send_row(1'b0);
            end else if (r < 74) begin
                send_row(1'b1);
            end else if (r < 83) begin
                row     = pick_row();
                partner = $urandom_range(0, 1) ? pick_neighbor(row) : ID_W'($urandom);
                send_item(make_preset(row, partner, $urandom_range(0, 1)));
            end else if (r < 93) begin
                send_item(make_read(pick_row()));
            end else if (r < 95) begin
                send_item(blank_item(OP_CLEAR));
            end else begin
                send_item(blank_item(OP_EDGE));
            end
        end
        // close any open row before the range moves
        row = pick_row();
        send_item(make_edge(row, pick_neighbor(row), pick_weight(), 1'b1));
    endtask

    // ---------------- result side ----------------

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_request = 1'b0;
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 99) < 15) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 4);
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_match_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with none pending: vertex %0d", o_vertex);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("vertex", want.vertex, o_vertex);
                check_field("partner", want.partner, o_partner);
                check_field("has_partner", want.has_partner, o_has_partner);
                check_field("status", want.status, o_status);
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        set_range(16'd100, 17'd108);
        send_item(make_preset(12'd2, 16'd500, 1'b1));
        send_item(make_read(12'd2));
        send_item(make_preset(12'd4095, 16'hFFFF, 1'b1));
        send_item(make_read(12'd4095));
        send_item(make_preset(12'd2, 16'hABCD, 1'b0));
        send_item(make_read(12'd2));
        // self edge, id below range, most negative weight, then the heaviest local
        send_item(make_edge(12'd0, 16'd100, 32'sd5, 1'b0));
        send_item(make_edge(12'd0, 16'd50, 32'h7FFF_FFFF, 1'b0));
        send_item(make_edge(12'd0, 16'd101, 32'h8000_0000, 1'b0));
        send_item(make_edge(12'd0, 16'd103, 32'h7FFF_FFFF, 1'b1));
        // taken local, self edge, partner below own id: both flags
        send_item(make_edge(12'd5, 16'd103, 32'sd10, 1'b0));
        send_item(make_edge(12'd5, 16'd105, 32'sd1, 1'b0));
        send_item(make_edge(12'd5, 16'd102, 32'sd0, 1'b1));
        // matched row reports its entry without a commit
        send_item(make_edge(12'd0, 16'd104, 32'sd9, 1'b1));
        // row outside the owned window: no result
        send_item(make_edge(12'd9, 16'd104, 32'sd9, 1'b1));
        // remote partner, then the same remote id is taken
        send_item(make_edge(12'd1, 16'd200, 32'sd7, 1'b1));
        send_item(make_edge(12'd4, 16'd200, 32'sd99, 1'b0));
        send_item(make_edge(12'd4, 16'hFFFF, 32'sd1, 1'b1));
        // no candidate, then partner precedes on its own
        send_item(make_edge(12'd7, 16'd99, 32'sd4, 1'b1));
        send_item(make_edge(12'd7, 16'd106, 32'sd4, 1'b1));
        // free row 6 again and check that a tie keeps the first neighbor
        send_item(make_preset(12'd6, 16'd0, 1'b0));
        send_item(make_edge(12'd6, 16'd300, 32'sd3, 1'b0));
        send_item(make_edge(12'd6, 16'd301, 32'sd3, 1'b1));
        send_item(blank_item(OP_CLEAR));
        send_item(make_read(12'd0));
    endtask

    task automatic test_range_extremes();
        logic [ID_W-1:0]  lo_list [6] = '{16'd0, 16'd65535, 16'd1000, 16'd0, 16'd65535,
                                          16'd61440};
        logic [END_W-1:0] hi_list [6] = '{17'd65536, 17'd65536, 17'd500, 17'd0, 17'd0,
                                          17'd65536};
        for (int k = 0; k < 6; k++) begin
            set_range(lo_list[k], hi_list[k]);
            run_random_mix(20);
        end
    endtask

    task automatic test_small_windows();
        logic [ID_W-1:0] lo;
        for (int k = 0; k < 4; k++) begin
            lo = $urandom_range(0, 65000);
            set_range(lo, lo + $urandom_range(2, 24));
            // one window runs with no gaps or stalls at all
            idle_enable = (k != 2);
            run_random_mix(50);
        end
        idle_enable = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_range(16'd200, 17'd216);
        idle_enable  = 1'b0;
        hold_request = 1'b1;
        run_random_mix(40);
        idle_enable = 1'b1;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_operation      <= OP_CLEAR;
        i_row            <= '0;
        i_neighbor       <= '0;
        i_weight         <= '0;
        i_last_in_row    <= 1'b0;
        i_preset_partner <= '0;
        i_preset_matched <= 1'b0;
        i_out_ready      <= 1'b0;
        range_lo_q = '0;
        range_hi_q = '0;
        clear_match_tables();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_range_extremes();
        test_small_windows();
        test_output_backpressure();

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (settle_cycles) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
